// ===== rtl/core/toeq_pkg.sv =====
// Package for the time-ordered event queue.
// Holds sizes, opcodes, status codes and the item and entry structs.
// No dependencies.
package toeq_pkg;

   localparam int DEPTH      = 16;
   localparam int STAMP_BITS = 32;
   localparam int FILL_BITS  = $clog2(DEPTH + 1);

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_POP    = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      op_type                op;
      logic                  kind;
      logic [STAMP_BITS-1:0] stamp;
   } req_type;

   typedef struct packed {
      status_type            status;
      logic                  popped_kind;
      logic [STAMP_BITS-1:0] popped_stamp;
      logic                  head_valid;
      logic                  head_kind;
      logic [STAMP_BITS-1:0] head_stamp;
      logic [FILL_BITS-1:0]  fill;
   } rsp_type;

   typedef struct packed {
      logic                  valid;
      logic                  kind;
      logic [STAMP_BITS-1:0] stamp;
   } entry_type;

   typedef struct packed {
      logic                  insert;
      logic                  pop;
      logic                  kind;
      logic [STAMP_BITS-1:0] stamp;
   } cell_ctl_type;

endpackage

// ===== rtl/core/time_ordered_event_queue.sv =====
// Top level of the time-ordered event queue: a chain of sorted cells.
// Depends on toeq_pkg and toeq_cell.
//
//   channel   handshake            payload
//   request   start / busy         req_item  (toeq_pkg::req_type)
//   response  rsp_strobe           rsp_item  (toeq_pkg::rsp_type)
//
// Each item is written into the cell chain when it is accepted; its response appears on the
// next cycle, and a new item can be taken every cycle while busy is low.
// Every cell compares its stamp against the new one in parallel, so the
// insert point costs one compare per cell and no search.
// Busy is high during reset and for the cycle after it, and low otherwise.
// The response is shown for one cycle only; the receiver cannot stall it.
module time_ordered_event_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  toeq_pkg::req_type   req_item,
   output logic                rsp_strobe,
   output toeq_pkg::rsp_type   rsp_item
);

   localparam int D = toeq_pkg::DEPTH;

   logic                              busy_ff;
   logic                              rsp_strobe_ff;
   toeq_pkg::rsp_type                 rsp_ff;
   toeq_pkg::rsp_type                 rsp_in;
   logic [toeq_pkg::FILL_BITS-1:0]    fill_ff;
   logic [toeq_pkg::FILL_BITS-1:0]    fill_in;
   logic                              accept;
   logic                              full;
   logic                              empty;
   toeq_pkg::cell_ctl_type            ctl;
   toeq_pkg::entry_type               entries   [D];
   toeq_pkg::entry_type               nexts     [D];
   logic                              gts       [D];
   toeq_pkg::entry_type               idle_entry;

   assign accept = start && !busy_ff;
   assign full   = (fill_ff == toeq_pkg::FILL_BITS'(D));
   assign empty  = (fill_ff == '0);

   assign idle_entry = '{valid: 1'b0, kind: 1'b0, stamp: '0};

   always_comb begin
      ctl.insert = accept && (req_item.op == toeq_pkg::OP_INSERT) && !full;
      ctl.pop    = accept && (req_item.op == toeq_pkg::OP_POP) && !empty;
      ctl.kind   = req_item.kind;
      ctl.stamp  = req_item.stamp;
   end

   for (genvar i = 0; i < D; i++) begin : g_cell
      toeq_pkg::entry_type left_entry;
      toeq_pkg::entry_type right_entry;
      logic                left_gt;

      if (i == 0) begin : g_first
         assign left_entry = idle_entry;
         assign left_gt    = 1'b0;
      end else begin : g_mid
         assign left_entry = entries[i-1];
         assign left_gt    = gts[i-1];
      end

      if (i == D - 1) begin : g_last
         assign right_entry = idle_entry;
      end else begin : g_inner
         assign right_entry = entries[i+1];
      end

      toeq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .left_entry  (left_entry),
         .left_gt     (left_gt),
         .right_entry (right_entry),
         .gt          (gts[i]),
         .entry       (entries[i]),
         .next_entry  (nexts[i])
      );
   end

   always_comb begin
      fill_in = fill_ff;
      if (ctl.insert) begin
         fill_in = fill_ff + 1'b1;
      end else if (ctl.pop) begin
         fill_in = fill_ff - 1'b1;
      end

      rsp_in              = '0;
      rsp_in.status       = toeq_pkg::ST_OK;
      if (req_item.op == toeq_pkg::OP_INSERT) begin
         if (full) begin
            rsp_in.status = toeq_pkg::ST_FULL;
         end
      end else if (empty) begin
         rsp_in.status = toeq_pkg::ST_EMPTY;
      end
      if (ctl.pop) begin
         rsp_in.popped_kind  = entries[0].kind;
         rsp_in.popped_stamp = entries[0].stamp;
      end
      if (nexts[0].valid) begin
         rsp_in.head_valid = 1'b1;
         rsp_in.head_kind  = nexts[0].kind;
         rsp_in.head_stamp = nexts[0].stamp;
      end
      rsp_in.fill = fill_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b1;
         rsp_strobe_ff <= 1'b0;
         fill_ff       <= '0;
      end else begin
         busy_ff       <= 1'b0;
         rsp_strobe_ff <= accept;
         fill_ff       <= fill_in;
      end
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign busy       = busy_ff;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

// ===== rtl/core/toeq_cell.sv =====
// One storage cell of the sorted event chain.
// Depends on toeq_pkg for the entry and control structs.
module toeq_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  toeq_pkg::cell_ctl_type ctl,
   input  toeq_pkg::entry_type   left_entry,
   input  logic                  left_gt,
   input  toeq_pkg::entry_type   right_entry,
   output logic                  gt,
   output toeq_pkg::entry_type   entry,
   output toeq_pkg::entry_type   next_entry
);

   logic                             valid_ff;
   logic                             kind_ff;
   logic [toeq_pkg::STAMP_BITS-1:0]  stamp_ff;
   toeq_pkg::entry_type              entry_in;
   toeq_pkg::entry_type              new_entry;

   assign entry = '{valid: valid_ff, kind: kind_ff, stamp: stamp_ff};

   // An empty cell counts as later than any time stamp.
   assign gt = !valid_ff || (stamp_ff > ctl.stamp);

   always_comb begin
      new_entry = '{valid: 1'b1, kind: ctl.kind, stamp: ctl.stamp};
      entry_in  = entry;
      if (ctl.insert && gt) begin
         entry_in = left_gt ? left_entry : new_entry;
      end else if (ctl.pop) begin
         entry_in = right_entry;
      end
   end

   assign next_entry = entry_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= entry_in.valid;
      end
      kind_ff  <= entry_in.kind;
      stamp_ff <= entry_in.stamp;
   end

endmodule

// ===== rtl/core/toeq_checker.sv =====
// Port-level checker for the time-ordered event queue, bound to the top level.
// Depends on toeq_pkg and time_ordered_event_queue.
module toeq_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_strobe,
   input toeq_pkg::rsp_type rsp_item
);

   localparam int D = toeq_pkg::DEPTH;

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_strobe)
      else $error("An accepted item gave no response.");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |=> !rsp_strobe)
      else $error("A response appeared without an accepted item.");

   a_empty_head: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_item.head_valid) |->
         (rsp_item.fill == '0 && rsp_item.head_stamp == '0 && !rsp_item.head_kind))
      else $error("Empty queue reported a head or a nonzero fill.");

   a_full_fill: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.status == toeq_pkg::ST_FULL) |->
         (rsp_item.fill == toeq_pkg::FILL_BITS'(D)))
      else $error("Dropped insert reported with a queue that is not full.");

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_item.fill <= toeq_pkg::FILL_BITS'(D)))
      else $error("Fill count beyond the queue depth.");

endmodule

bind time_ordered_event_queue toeq_checker u_toeq_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_item   (rsp_item)
);

// ===== tb/tb_time_ordered_event_queue.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for time_ordered_event_queue: directed and random inserts and pops
// against a sorted-queue predictor, with response checking on every strobe.
// Depends on toeq_pkg and the time_ordered_event_queue RTL.
module tb_time_ordered_event_queue;
   import toeq_pkg::*;

   localparam int ITEM_TOTAL     = 900;
   localparam int QUIET_TAIL     = 150;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int MAX_REPORTS    = 10;

   class event_order_board;
      entry_type held[$];
      rsp_type   pending[$];
      int        mismatches;
      int        reported;
      int        checked;
      int        inserts;
      int        pops;
      int        drops_full;
      int        pops_empty;
      int        tie_inserts;

      function void note_request(req_type item);
         rsp_type   want;
         entry_type fresh;
         int        pos;
         want = '0;
         want.status = ST_OK;
         if (item.op == OP_INSERT) begin
            inserts++;
            if (held.size() >= DEPTH) begin
               want.status = ST_FULL;
               drops_full++;
            end else begin
               pos = 0;
               while (pos < held.size() && held[pos].stamp <= item.stamp) pos++;
               if (pos > 0 && held[pos-1].stamp == item.stamp) tie_inserts++;
               fresh.valid = 1'b1;
               fresh.kind  = item.kind;
               fresh.stamp = item.stamp;
               held.insert(pos, fresh);
            end
         end else begin
            pops++;
            if (held.size() == 0) begin
               want.status = ST_EMPTY;
               pops_empty++;
            end else begin
               fresh = held.pop_front();
               want.popped_kind  = fresh.kind;
               want.popped_stamp = fresh.stamp;
            end
         end
         if (held.size() > 0) begin
            want.head_valid = 1'b1;
            want.head_kind  = held[0].kind;
            want.head_stamp = held[0].stamp;
         end
         want.fill = FILL_BITS'(held.size());
         pending.push_back(want);
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         checked++;
         if (pending.size() == 0) begin
            mismatches++;
            if (reported < MAX_REPORTS) begin
               reported++;
               $display("ERROR: unexpected response status=%0d fill=%0d", got.status, got.fill);
            end
            return;
         end
         want = pending.pop_front();
         if (got.status !== want.status || got.popped_kind !== want.popped_kind ||
             got.popped_stamp !== want.popped_stamp || got.head_valid !== want.head_valid ||
             got.head_kind !== want.head_kind || got.head_stamp !== want.head_stamp ||
             got.fill !== want.fill) begin
            mismatches++;
            if (reported < MAX_REPORTS) begin
               reported++;
               $display("ERROR: response %0d mismatch", checked);
               $display("  expected status=%0d popped=%0d/%h head=%0d/%0d/%h fill=%0d",
                        want.status, want.popped_kind, want.popped_stamp, want.head_valid,
                        want.head_kind, want.head_stamp, want.fill);
               $display("  actual   status=%0d popped=%0d/%h head=%0d/%0d/%h fill=%0d",
                        got.status, got.popped_kind, got.popped_stamp, got.head_valid,
                        got.head_kind, got.head_stamp, got.fill);
            end
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_strobe;
   rsp_type rsp_item;

   event_order_board board = new();
   int items_sent;
   int quiet_cycles = 0;

   time_ordered_event_queue dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((start && !busy) || rsp_strobe) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (start && !busy) board.note_request(req_item);
         if (rsp_strobe) board.check_response(rsp_item);
      end
   end

   function automatic req_type make_insert(logic kind, logic [STAMP_BITS-1:0] stamp);
      req_type item;
      item.op    = OP_INSERT;
      item.kind  = kind;
      item.stamp = stamp;
      return item;
   endfunction

   function automatic req_type make_pop();
      req_type item;
      item.op    = OP_POP;
      item.kind  = 1'($urandom);
      item.stamp = $urandom;
      return item;
   endfunction

   function automatic logic [STAMP_BITS-1:0] pick_stamp();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel <= 2) return {16'($urandom_range(0, 3)), 16'h0000};
      if (sel == 3) return ($urandom_range(0, 1) == 0) ? '0 : '1;
      return $urandom;
   endfunction

   task automatic send_item(req_type item);
      req_item <= item;
      start    <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
   endtask

   task automatic idle_for(int cycles);
      start    <= 1'b0;
      req_item <= req_type'($bits(req_type)'({$urandom, $urandom}));
      repeat (cycles) @(posedge clock);
   endtask

   task automatic run_directed();
      send_item(make_pop());
      send_item(make_insert(1'b1, 32'hFFFF_FFFF));
      send_item(make_insert(1'b0, 32'h0000_0000));
      send_item(make_insert(1'b1, 32'h0000_0000));
      send_item(make_insert(1'b0, 32'h0001_8000));
      send_item(make_insert(1'b1, 32'h0001_8000));
      send_item(make_pop());
      for (int i = 0; i < 12; i++) begin
         send_item(make_insert(1'(i), {16'(i % 3), 16'h8000}));
      end
      send_item(make_insert(1'b0, 32'h0000_0001));
      send_item(make_pop());
      send_item(make_pop());
   endtask

   task automatic run_random();
      int seg_len;
      int insert_pct;
      int idle_pct;
      while (items_sent < ITEM_TOTAL) begin
         seg_len = $urandom_range(10, 40);
         case ($urandom_range(0, 2))
            0: insert_pct = 85;
            1: insert_pct = 50;
            default: insert_pct = 15;
         endcase
         idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 30;
         for (int n = 0; n < seg_len && items_sent < ITEM_TOTAL; n++) begin
            if (items_sent < ITEM_TOTAL - QUIET_TAIL && $urandom_range(0, 99) < idle_pct)
               idle_for($urandom_range(1, 7));
            if ($urandom_range(0, 99) < insert_pct)
               send_item(make_insert(1'($urandom), pick_stamp()));
            else
               send_item(make_pop());
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      run_random();
      idle_for(1);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      $display("Ran %0d items: %0d inserts (%0d dropped when full, %0d equal-time), %0d pops",
               items_sent, board.inserts, board.drops_full, board.tie_inserts, board.pops);
      $display("Pops on empty queue: %0d; responses checked: %0d; mismatches: %0d",
               board.pops_empty, board.checked, board.mismatches + board.pending.size());
      if (board.mismatches == 0 && board.pending.size() == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

   initial begin
      @(negedge reset);
      while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("Watchdog expired after %0d cycles with no handshake", quiet_cycles);
      $display("Regression FAIL");
      $finish;
   end

endmodule
